[rtl/core/ttui_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttui_pkg: shared types and constants of the text to unsigned integer parser
// Beat payloads, parse phases, digit status codes and character codes.
// ----------------------------------------------------------------------------
package ttui_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int POSITION_BITS = 16;
  localparam int BASE_BITS     = 6;
  localparam int CH_BITS       = 8;
  localparam int DIGIT_BITS    = 7;
  localparam int PROD_BITS     = VALUE_BITS + BASE_BITS + 1;

  localparam logic [CH_BITS-1:0] CH_SPACE = 8'd32;
  localparam logic [CH_BITS-1:0] CH_TAB   = 8'd9;
  localparam logic [CH_BITS-1:0] CH_CR    = 8'd13;
  localparam logic [CH_BITS-1:0] CH_PLUS  = 8'd43;
  localparam logic [CH_BITS-1:0] CH_MINUS = 8'd45;
  localparam logic [CH_BITS-1:0] CH_ZERO  = 8'd48;
  localparam logic [CH_BITS-1:0] CH_NINE  = 8'd57;
  localparam logic [CH_BITS-1:0] CH_UPPER_A = 8'd65;
  localparam logic [CH_BITS-1:0] CH_UPPER_Z = 8'd90;
  localparam logic [CH_BITS-1:0] CH_LOWER_A = 8'd97;
  localparam logic [CH_BITS-1:0] CH_LOWER_Z = 8'd122;
  localparam logic [CH_BITS-1:0] CH_UPPER_X = 8'd88;
  localparam logic [CH_BITS-1:0] CH_LOWER_X = 8'd120;

  localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;

  localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 7'd99;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SPACE  = 3'd1,
    PH_SIGNED = 3'd2,
    PH_ZERO   = 3'd3,
    PH_DIGITS = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    DS_NONE   = 2'd0,
    DS_DIGITS = 2'd1,
    DS_OVF    = 2'd2
  } dstat_t;

  typedef struct packed {
    logic [CH_BITS-1:0] ch;
    logic               start_req;
  } in_beat_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]    value;
    logic [POSITION_BITS-1:0] end_offset;
    logic                     converted;
    logic                     overflowed;
  } out_beat_t;

  typedef struct packed {
    logic                  accept;
    logic                  overflow;
    logic [VALUE_BITS-1:0] acc;
  } digit_res_t;

endpackage

[rtl/core/text_to_unsigned_integer_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_to_unsigned_integer_parser_top: streaming text to unsigned integer
// One character per beat; a start mark opens a new string. Emits one result
// beat (value, end offset, flags) on the first character that ends a number.
// ----------------------------------------------------------------------------
// The block takes one character beat in every clock cycle unless a waiting
// result stalls it. A beat is held in an input register; when it advances,
// the per-character update (one 32 x 6 bit multiply-add with overflow test,
// plus phase logic) writes the parse state and, when the string ends, the
// result register, from which the result beat is offered.
// A waiting result stalls input only while out_ready is low. Write
// number_base only while no string is being parsed.
module text_to_unsigned_integer_parser_top
  import ttui_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [BASE_BITS-1:0] cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_data
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [BASE_BITS-1:0]     number_base;
  logic                     q_valid;
  in_beat_t                 q_beat;
  logic                     adv;

  phase_t                   phase, phase_next, phase_eff;
  logic [VALUE_BITS-1:0]    acc, acc_next, acc_eff;
  dstat_t                   status, status_next, status_eff;
  logic                     neg, neg_next, neg_eff;
  logic [BASE_BITS-1:0]     abase, abase_next, abase_eff;
  logic [POSITION_BITS-1:0] pos, pos_next, pos_eff;

  logic                     live, is_space, is_minus, is_plus, is_zero, is_x;
  logic                     auto_base, zero_prefix, first, first_zero, take, emit;
  logic [BASE_BITS-1:0]     dig_base;
  digit_res_t               dig;
  out_beat_t                res_next;

  assign adv      = q_valid && (!out_valid || out_ready);
  assign in_ready = !q_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_AUTO;
    end else if (cfg_wr_en) begin
      number_base <= cfg_wr_data;
    end
  end

  // hold the accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_beat <= in_data;
    end
  end

  // state as seen by this character
  always_comb begin
    live       = q_beat.start_req || (phase != PH_IDLE);
    phase_eff  = q_beat.start_req ? PH_SPACE : phase;
    acc_eff    = q_beat.start_req ? '0 : acc;
    status_eff = q_beat.start_req ? DS_NONE : status;
    neg_eff    = q_beat.start_req ? 1'b0 : neg;
    abase_eff  = q_beat.start_req ? BASE_AUTO : abase;
    if (q_beat.start_req) begin
      pos_eff = '0;
    end else if (pos == POS_MAX) begin
      pos_eff = pos;
    end else begin
      pos_eff = pos + 1'b1;
    end
  end

  always_comb begin
    is_space    = (q_beat.ch == CH_SPACE) || (q_beat.ch inside {[CH_TAB:CH_CR]});
    is_minus    = q_beat.ch == CH_MINUS;
    is_plus     = q_beat.ch == CH_PLUS;
    is_zero     = q_beat.ch == CH_ZERO;
    is_x        = (q_beat.ch == CH_LOWER_X) || (q_beat.ch == CH_UPPER_X);
    auto_base   = number_base == BASE_AUTO;
    zero_prefix = auto_base || (number_base == BASE_HEX);
    first       = (phase_eff == PH_SIGNED)
               || ((phase_eff == PH_SPACE) && !is_space && !is_minus && !is_plus);
    first_zero  = first && zero_prefix && is_zero;
    if (first) begin
      dig_base = auto_base ? BASE_DEC : number_base;
    end else begin
      dig_base = (abase_eff == BASE_AUTO) ? BASE_DEC : abase_eff;
    end
    take = live && ((first && !first_zero)
                 || ((phase_eff == PH_ZERO) && !is_x)
                 || (phase_eff == PH_DIGITS));
  end

  ttui_digit u_digit (
    .ch   (q_beat.ch),
    .base (dig_base),
    .acc  (acc_eff),
    .res  (dig)
  );

  assign emit = take && !dig.accept;

  // next phase
  always_comb begin
    phase_next = phase;
    if (adv && live) begin
      case (phase_eff)
        PH_SPACE: begin
          if (is_space) begin
            phase_next = PH_SPACE;
          end else if (is_minus || is_plus) begin
            phase_next = PH_SIGNED;
          end else if (first_zero) begin
            phase_next = PH_ZERO;
          end else begin
            phase_next = PH_DIGITS;
          end
        end
        PH_SIGNED: begin
          phase_next = first_zero ? PH_ZERO : PH_DIGITS;
        end
        PH_ZERO:   phase_next = PH_DIGITS;
        PH_DIGITS: phase_next = PH_DIGITS;
        default:   phase_next = PH_IDLE;
      endcase
      if (emit) begin
        phase_next = PH_IDLE;
      end
    end
  end

  // next parse data
  always_comb begin
    acc_next    = acc;
    status_next = status;
    neg_next    = neg;
    abase_next  = abase;
    pos_next    = pos;
    if (adv && live) begin
      acc_next    = acc_eff;
      status_next = status_eff;
      neg_next    = neg_eff;
      abase_next  = abase_eff;
      pos_next    = pos_eff;
      if ((phase_eff == PH_SPACE) && is_minus) begin
        neg_next = 1'b1;
      end
      if (first_zero) begin
        abase_next  = auto_base ? BASE_OCT : BASE_HEX;
        acc_next    = '0;
        status_next = DS_DIGITS;
      end else if (first) begin
        abase_next = auto_base ? BASE_DEC : number_base;
      end
      if ((phase_eff == PH_ZERO) && is_x) begin
        abase_next  = BASE_HEX;
        acc_next    = '0;
        status_next = DS_NONE;
      end
      if (take && dig.accept && (status_eff != DS_OVF)) begin
        if (dig.overflow) begin
          status_next = DS_OVF;
          acc_next    = '1;
        end else begin
          status_next = DS_DIGITS;
          acc_next    = dig.acc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      status <= DS_NONE;
    end else begin
      phase  <= phase_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    acc   <= acc_next;
    neg   <= neg_next;
    abase <= abase_next;
    pos   <= pos_next;
  end

  always_comb begin
    res_next.value      = (neg_eff && (status_eff == DS_DIGITS)) ? (~acc_eff + 1'b1) : acc_eff;
    res_next.end_offset = (status_eff != DS_NONE) ? pos_eff : '0;
    res_next.converted  = status_eff != DS_NONE;
    res_next.overflowed = status_eff == DS_OVF;
  end

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && live && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && live && emit) begin
      out_data <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_new_result_from_beat: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(adv))
    else $error("result beat appeared without a processed character");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (rst)
    (adv && live && emit) |=> (phase == PH_IDLE))
    else $error("parser not idle after a result");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.overflowed) |->
      (out_data.converted && (out_data.value == '1)))
    else $error("overflowed result not saturated");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.converted) |->
      ((out_data.end_offset == '0) && (out_data.value == '0)))
    else $error("unconverted result carries data");
`endif

endmodule

[rtl/core/ttui_digit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttui_digit: digit decode and multiply-accumulate
// Decodes one character as a digit, checks it against the base and forms
// acc * base + digit with an overflow flag.
// ----------------------------------------------------------------------------
module ttui_digit
  import ttui_pkg::*;
(
  input  logic [CH_BITS-1:0]    ch,
  input  logic [BASE_BITS-1:0]  base,
  input  logic [VALUE_BITS-1:0] acc,
  output digit_res_t            res
);

  logic [DIGIT_BITS-1:0] dval;
  logic [PROD_BITS-1:0]  prod;

  always_comb begin
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      dval = DIGIT_BITS'(ch - CH_ZERO);
    end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      dval = DIGIT_BITS'(ch - CH_UPPER_A + 8'd10);
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      dval = DIGIT_BITS'(ch - CH_LOWER_A + 8'd10);
    end else begin
      dval = DIGIT_NONE;
    end
  end

  always_comb begin
    prod         = PROD_BITS'(acc) * PROD_BITS'(base) + PROD_BITS'(dval);
    res.accept   = dval < {1'b0, base};
    res.overflow = |prod[PROD_BITS-1:VALUE_BITS];
    res.acc      = prod[VALUE_BITS-1:0];
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the text to unsigned integer parser
// Streams strings one character per beat, predicts each parsed number on the
// bench side and checks every result beat. Covers auto, octal, decimal, hex,
// odd and oversized bases, plus random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import ttui_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_GUARD   = 5000;

  typedef struct packed {
    logic [3:0] hold;
    in_beat_t   beat;
  } char_slot_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [BASE_BITS-1:0] cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_beat_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_beat_t            out_data;

  text_to_unsigned_integer_parser_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  always #5 clk = ~clk;

  // bench copy of the parser state
  logic [BASE_BITS-1:0]     num_base = BASE_AUTO;
  phase_t                   cur_phase = PH_IDLE;
  logic [VALUE_BITS-1:0]    acc_val = '0;
  dstat_t                   dig_stat = DS_NONE;
  logic                     neg_sign = 1'b0;
  logic [BASE_BITS-1:0]     lat_base = '0;
  logic [POSITION_BITS-1:0] char_pos = '0;

  char_slot_t  chars_pending[$];
  out_beat_t   numbers_due[$];
  char_slot_t  slot;
  out_beat_t   predicted;
  out_beat_t   want;
  int unsigned idle_count = 0;
  int unsigned rdy_hold = 0;
  int unsigned rcv_draw;
  int unsigned send_gap_max = 12;
  int unsigned rcv_gap_max = 12;

  int fail_count = 0;
  int chars_taken = 0;
  int items_pushed = 0;
  int strings_started = 0;
  int base_settings = 0;
  int numbers_checked = 0;
  int overflow_count = 0;
  int empty_count = 0;

  function automatic logic [DIGIT_BITS-1:0] digit_of(logic [CH_BITS-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return DIGIT_BITS'(c - CH_ZERO);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return DIGIT_BITS'(c - CH_UPPER_A + 8'd10);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return DIGIT_BITS'(c - CH_LOWER_A + 8'd10);
    return DIGIT_NONE;
  endfunction

  function automatic bit finish_number(output out_beat_t r);
    r.value      = (neg_sign && dig_stat == DS_DIGITS) ? -acc_val : acc_val;
    r.end_offset = (dig_stat != DS_NONE) ? char_pos : '0;
    r.converted  = (dig_stat != DS_NONE);
    r.overflowed = (dig_stat == DS_OVF);
    cur_phase = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic bit take_digit(logic [CH_BITS-1:0] c, output out_beat_t r);
    logic [BASE_BITS-1:0]  radix;
    logic [DIGIT_BITS-1:0] d;
    logic [63:0]           prod;
    r = '0;
    radix = (lat_base != '0) ? lat_base : BASE_DEC;
    d = digit_of(c);
    if (d >= radix) return finish_number(r);
    if (dig_stat == DS_OVF) return 1'b0;
    prod = 64'(acc_val) * 64'(radix) + 64'(d);
    if (prod > 64'hFFFF_FFFF) begin
      dig_stat = DS_OVF;
      acc_val = '1;
    end else begin
      dig_stat = DS_DIGITS;
      acc_val = prod[VALUE_BITS-1:0];
    end
    return 1'b0;
  endfunction

  function automatic bit first_char(logic [CH_BITS-1:0] c, output out_beat_t r);
    r = '0;
    if ((num_base == BASE_AUTO || num_base == BASE_HEX) && c == CH_ZERO) begin
      lat_base = (num_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
      acc_val = '0;
      dig_stat = DS_DIGITS;
      cur_phase = PH_ZERO;
      return 1'b0;
    end
    lat_base = (num_base == BASE_AUTO) ? BASE_DEC : num_base;
    cur_phase = PH_DIGITS;
    return take_digit(c, r);
  endfunction

  function automatic bit parse_char(in_beat_t b, output out_beat_t r);
    r = '0;
    if (b.start_req) begin
      acc_val = '0;
      dig_stat = DS_NONE;
      neg_sign = 1'b0;
      lat_base = '0;
      char_pos = '0;
      cur_phase = PH_SPACE;
    end else begin
      if (cur_phase == PH_IDLE) return 1'b0;
      if (char_pos != '1) char_pos++;
    end
    case (cur_phase)
      PH_SPACE: begin
        if (b.ch == CH_SPACE || (b.ch >= CH_TAB && b.ch <= CH_CR)) return 1'b0;
        if (b.ch == CH_MINUS) begin
          neg_sign = 1'b1;
          cur_phase = PH_SIGNED;
          return 1'b0;
        end
        if (b.ch == CH_PLUS) begin
          cur_phase = PH_SIGNED;
          return 1'b0;
        end
        return first_char(b.ch, r);
      end
      PH_SIGNED: return first_char(b.ch, r);
      PH_ZERO: begin
        if (b.ch == CH_LOWER_X || b.ch == CH_UPPER_X) begin
          lat_base = BASE_HEX;
          acc_val = '0;
          dig_stat = DS_NONE;
          cur_phase = PH_DIGITS;
          return 1'b0;
        end
        cur_phase = PH_DIGITS;
        return take_digit(b.ch, r);
      end
      PH_DIGITS: return take_digit(b.ch, r);
      default: begin
        cur_phase = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report(string what, out_beat_t exp_beat, out_beat_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] %s: expected value=%h offset=%0d conv=%b ovf=%b,", $realtime, what,
               exp_beat.value, exp_beat.end_offset, exp_beat.converted, exp_beat.overflowed,
               " got value=%h offset=%0d conv=%b ovf=%b",
               got.value, got.end_offset, got.converted, got.overflowed);
  endtask

  // character driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      idle_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        chars_taken++;
        if (parse_char(in_data, predicted)) numbers_due.push_back(predicted);
      end
      if (!in_valid || in_ready) begin
        if (chars_pending.size() != 0 && idle_count >= chars_pending[0].hold) begin
          slot = chars_pending.pop_front();
          in_data <= slot.beat;
          in_valid <= 1'b1;
          idle_count <= 0;
        end else begin
          in_valid <= 1'b0;
          if (chars_pending.size() != 0) idle_count <= idle_count + 1;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rdy_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (numbers_due.size() == 0) begin
          report("unexpected result", '0, out_data);
        end else begin
          want = numbers_due.pop_front();
          numbers_checked++;
          if (want.overflowed) overflow_count++;
          if (!want.converted) empty_count++;
          if (out_data !== want) report("result mismatch", want, out_data);
        end
        rcv_draw = $urandom_range(0, rcv_gap_max);
        rdy_hold <= rcv_draw;
        out_ready <= (rcv_draw == 0);
      end else if (rdy_hold != 0) begin
        rdy_hold <= rdy_hold - 1;
        out_ready <= (rdy_hold == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_char(logic [CH_BITS-1:0] c, bit st);
    char_slot_t s;
    s.hold = 4'($urandom_range(0, send_gap_max));
    s.beat.ch = c;
    s.beat.start_req = st;
    chars_pending.push_back(s);
    items_pushed++;
    if (st) strings_started++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == 0);
  endtask

  function automatic logic [CH_BITS-1:0] digit_char(int v);
    if (v < 10) return CH_BITS'(CH_ZERO + v);
    return CH_BITS'((($urandom_range(0, 1) != 0) ? CH_UPPER_A : CH_LOWER_A) + v - 10);
  endfunction

  task automatic push_noise();
    repeat ($urandom_range(1, 6))
      push_char(CH_BITS'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  task automatic push_string(logic [BASE_BITS-1:0] b);
    int         radix;
    int         n;
    int         pick;
    bit         first;
    logic [7:0] c;
    first = 1'b1;
    radix = (b == BASE_AUTO) ? 10 : (b > 36) ? 36 : b;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      c = ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_BITS'($urandom_range(CH_TAB, CH_CR));
      push_char(c, first);
      first = 1'b0;
    end
    pick = $urandom_range(0, 3);
    if (pick < 2) begin
      push_char((pick == 0) ? CH_MINUS : CH_PLUS, first);
      first = 1'b0;
    end
    if (b == BASE_AUTO || b == BASE_HEX) begin
      pick = $urandom_range(0, 3);
      if (pick < 2) begin
        push_char(CH_ZERO, first);
        first = 1'b0;
        radix = (b == BASE_AUTO) ? 8 : 16;
      end
      if (pick == 0) begin
        push_char(($urandom_range(0, 1) != 0) ? CH_LOWER_X : CH_UPPER_X, first);
        radix = 16;
      end
    end
    pick = $urandom_range(0, 9);
    n = (pick == 0) ? 0 : (pick < 3) ? $urandom_range(9, 34) : $urandom_range(1, 8);
    repeat (n) begin
      push_char(digit_char($urandom_range(0, radix - 1)), first);
      first = 1'b0;
    end
    pick = $urandom_range(0, 7);
    if (pick != 0) begin
      case (pick % 4)
        0: c = CH_BITS'($urandom_range(0, 255));
        1: c = CH_BITS'($urandom_range(128, 255));
        2: c = CH_SPACE;
        default: c = CH_BITS'($urandom_range(33, 47));
      endcase
      push_char(c, first);
    end
  endtask

  task automatic set_base(logic [BASE_BITS-1:0] b);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    num_base = b;
    base_settings++;
    @(negedge clk);
  endtask

  // hold until every character is taken and every number has come back
  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    while (chars_pending.size() != 0 || in_valid) @(negedge clk);
    while (numbers_due.size() != 0 && guard < DRAIN_GUARD) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (numbers_due.size() != 0) report("missing result", numbers_due.pop_front(), '0);
  endtask

  initial begin
    int                   mark;
    int                   n_str;
    logic [BASE_BITS-1:0] b;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_base(BASE_AUTO);
    push_text("+123;");
    push_text("0xz");
    push_text("0 ");
    push_text(" -7!");
    push_text("+ ");
    push_text("5");
    push_text("9.");
    push_char("A", 1'b0);
    drain();

    set_base(6'd36);
    push_text("zZzZzZz.");
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: b = BASE_AUTO;
        1: b = BASE_HEX;
        2: b = BASE_DEC;
        3: b = BASE_OCT;
        4: b = 6'd2;
        5: b = 6'd36;
        6: b = 6'd1;
        7: b = 6'd37;
        8: b = 6'd63;
        default: b = BASE_BITS'($urandom_range(0, 63));
      endcase
      set_base(b);
      rcv_gap_max = (ph % 3 == 1) ? 0 : 12;
      mark = items_pushed;
      n_str = 0;
      while (items_pushed - mark < 200) begin
        if (n_str % 8 == 0) begin
          case ($urandom_range(0, 2))
            0: send_gap_max = 0;
            1: send_gap_max = 3;
            default: send_gap_max = 12;
          endcase
        end
        if ($urandom_range(0, 4) == 0) push_noise();
        else push_string(b);
        n_str++;
      end
      push_char(".", 1'b1);
      drain();
    end

    $display("Summary: %0d characters in %0d strings over %0d base settings;",
             chars_taken, strings_started, base_settings);
    $display("Summary: %0d numbers checked, %0d overflowed, %0d with no digit converted.",
             numbers_checked, overflow_count, empty_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/core/ttui_pkg.sv
rtl/core/ttui_digit.sv
rtl/core/text_to_unsigned_integer_parser_top.sv
tb/testbench.sv
